/* rtl/core/ppbc_pkg.sv */
package ppbc_pkg;

  // counter bank
  localparam int unsigned NUM_CNT   = 5;
  localparam int unsigned CNT_IDX_W = 3;
  localparam int unsigned CNT_W     = 16;

  // configuration registers
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned THR_W      = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_ONE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_TWO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_THREE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FIVE     = 3'd5;

  typedef logic [THR_W-1:0] thr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd900;
  localparam thr_t THR_RST [NUM_CNT] = '{14'd10, 14'd25, 14'd50, 14'd100, 14'd200};

  // bin = floor(sum * BIN_NUM / (n * BIN_DEN))
  localparam int unsigned BIN_NUM_W = 12;
  localparam int unsigned BIN_DEN_W = 11;
  localparam logic [BIN_NUM_W-1:0] BIN_NUM = 12'd3125;
  localparam logic [BIN_DEN_W-1:0] BIN_DEN = 11'd1536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_SCALE,
    S_CRD,
    S_CWR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } win_cmd_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic                 clear_all;
    logic [CNT_IDX_W-1:0] addr;
    cnt_t                 wdata;
  } cnt_cmd_t;

endpackage

/* rtl/core/ppbc_window.sv */
module ppbc_window #(
  parameter int unsigned WINDOW_LEN  = 8,
  parameter int unsigned SAMPLE_BITS = 12,
  localparam int unsigned SUM_W      = SAMPLE_BITS + $clog2(WINDOW_LEN),
  localparam int unsigned FILL_W     = $clog2(WINDOW_LEN + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ppbc_pkg::win_cmd_t     cmd_i,
  input  logic [SAMPLE_BITS-1:0] code_i,
  output logic [SUM_W-1:0]       sum_o,
  output logic [FILL_W-1:0]      fill_o
);
  import ppbc_pkg::*;

  localparam int unsigned PTR_W = $clog2(WINDOW_LEN);

  logic [SAMPLE_BITS-1:0] mem [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic                   full;

  // circular buffer, ptr points at the oldest entry once full
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      old_q <= mem[ptr_q];
    end
    if (cmd_i.wr) begin
      mem[ptr_q] <= code_i;
    end
  end

  assign full = (fill_q == FILL_W'(WINDOW_LEN));

  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    ptr_d  = ptr_q;
    if (cmd_i.clear) begin
      sum_d  = '0;
      fill_d = '0;
      ptr_d  = '0;
    end else if (cmd_i.wr) begin
      sum_d = sum_q + SUM_W'(code_i) - (full ? SUM_W'(old_q) : SUM_W'(0));
      if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end
      ptr_d = (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? PTR_W'(0) : ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_LEN))
    else $error("window fill beyond window length");

  a_ptr_follows_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full) |-> (FILL_W'(ptr_q) == fill_q))
    else $error("write pointer out of step with fill while filling");

endmodule

/* rtl/core/ppbc_counters.sv */
module ppbc_counters (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppbc_pkg::cnt_cmd_t cmd_i,
  output ppbc_pkg::cnt_t     rd_val_o
);
  import ppbc_pkg::*;

  cnt_t               mem [NUM_CNT];
  cnt_t               rdata_q;
  logic               rvld_q;
  logic [NUM_CNT-1:0] vld_q;

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[cmd_i.addr];
    end
    if (cmd_i.wr) begin
      mem[cmd_i.addr] <= cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.rd) begin
        rvld_q <= vld_q[cmd_i.addr];
      end
      if (cmd_i.clear_all) begin
        vld_q <= '0;
      end else if (cmd_i.wr) begin
        vld_q[cmd_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_val_o = rvld_q ? rdata_q : '0;

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd && cmd_i.wr))
    else $error("counter read and write in the same cycle");

endmodule

/* rtl/core/particle_pulse_bin_counter_core.sv */
// particle pulse bin counter
//
// input stream (s_axis_*): one 12-bit converter code per transaction.
// each code enters an eight-sample window; the window mean is scaled to a
// bin and every counter whose threshold lies above a nonzero bin counts up.
// output stream (m_axis_*): one transaction per measurement, after
// sample_limit samples, carrying the five counts; counters, window and
// sample index then clear.
// config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 sample_limit, 1..5 thresholds); unused indexes are ignored.
// flow: after acceptance the block is not ready again until the item is done,
// set by the counter bank memory: each of the five counters is read
// and written back in the next cycle. a result is moved to the output
// register in the last step after the sample that ends the measurement.
// a finished result waits in an output register; the block keeps taking
// samples and only holds in its last step if a new result is due while
// the previous one is still stalled.
// reset: registers return to their defaults, counters and window empty.
module particle_pulse_bin_counter_core #(
  parameter int unsigned WINDOW_LEN  = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // s_axis_tdata: sample_code
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // m_axis_tdata: count_one, count_two, count_three, count_four, count_five
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ppbc_pkg::NUM_CNT*ppbc_pkg::CNT_W-1:0] m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic [ppbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ppbc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import ppbc_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned NUM_W  = SUM_W + BIN_NUM_W;
  localparam int unsigned DEN_W  = FILL_W + BIN_DEN_W;
  localparam int unsigned PROD_W = THR_W + DEN_W;
  localparam int unsigned CMP_W  = (NUM_W > PROD_W) ? NUM_W : PROD_W;
  localparam int unsigned OUT_W  = NUM_CNT * CNT_W;

  state_e                    state_q, state_d;
  logic [SAMPLE_BITS-1:0]    code_q;
  logic [NUM_W-1:0]          num_q;
  logic [DEN_W-1:0]          den_q;
  logic [PROD_W-1:0]         prod_q;
  logic [LIMIT_W-1:0]        idx_q, idx_sat;
  logic                      end_q;
  logic [CNT_IDX_W-1:0]      k_q;
  cnt_t                      res_q [NUM_CNT];
  logic [OUT_W-1:0]          out_q;
  logic                      out_valid_q;
  logic [LIMIT_W-1:0]        limit_q;
  thr_t                      thr_q [NUM_CNT];

  win_cmd_t                  win_cmd;
  cnt_cmd_t                  cnt_cmd;
  logic [SUM_W-1:0]          win_sum;
  logic [FILL_W-1:0]         win_fill;
  cnt_t                      cnt_rd;
  cnt_t                      cnt_new;
  logic                      acc, out_go, last_k;
  logic                      bin_pos, bin_below, inc;

  assign acc    = s_axis_tvalid && s_axis_tready;
  assign last_k = (k_q == CNT_IDX_W'(NUM_CNT - 1));
  // result moves to the output register once the previous one is gone
  assign out_go = (state_q == S_DONE) && end_q && (!out_valid_q || m_axis_tready);

  ppbc_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (win_cmd),
    .code_i(code_q),
    .sum_o (win_sum),
    .fill_o(win_fill)
  );

  ppbc_counters u_counters (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cnt_cmd),
    .rd_val_o(cnt_rd)
  );

  // bin > 0 and bin < thr, checked without a divider:
  // floor(a/d) >= 1 <=> a >= d, floor(a/d) < t <=> a < t*d
  assign bin_pos   = CMP_W'(num_q) >= CMP_W'(den_q);
  assign bin_below = CMP_W'(num_q) < CMP_W'(prod_q);
  assign inc       = bin_pos && bin_below && (cnt_rd != '1);
  assign cnt_new   = cnt_rd + CNT_W'(inc);

  assign idx_sat = (idx_q == '1) ? idx_q : idx_q + LIMIT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (acc) state_d = S_WIN;
      S_WIN:   state_d = S_SCALE;
      S_SCALE: state_d = S_CRD;
      S_CRD:   state_d = S_CWR;
      S_CWR:   state_d = last_k ? S_DONE : S_CRD;
      S_DONE:  if (!end_q || out_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready     = 1'b0;
    win_cmd           = '0;
    cnt_cmd           = '0;
    cnt_cmd.addr      = k_q;
    cnt_cmd.wdata     = cnt_new;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_WIN: begin
        win_cmd.wr = 1'b1;
      end
      S_CRD: begin
        cnt_cmd.rd = 1'b1;
      end
      S_CWR: begin
        cnt_cmd.wr = 1'b1;
      end
      S_DONE: begin
        win_cmd.clear     = out_go;
        cnt_cmd.clear_all = out_go;
      end
      default: ;
    endcase
    // oldest sample is read while the new one is being taken
    win_cmd.rd = acc;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      end_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SCALE) begin
        idx_q <= idx_sat;
        end_q <= (idx_sat >= limit_q);
        k_q   <= '0;
      end
      if (state_q == S_CWR && !last_k) begin
        k_q <= k_q + CNT_IDX_W'(1);
      end
      if (out_go) begin
        idx_q <= '0;
      end
      if (out_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      code_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (state_q == S_SCALE) begin
      num_q <= NUM_W'(win_sum) * NUM_W'(BIN_NUM);
      den_q <= DEN_W'(win_fill) * DEN_W'(BIN_DEN);
    end
    if (state_q == S_CRD) begin
      prod_q <= PROD_W'(thr_q[k_q]) * PROD_W'(den_q);
    end
    if (state_q == S_CWR) begin
      res_q[k_q] <= cnt_new;
    end
    if (out_go) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        out_q[i*CNT_W +: CNT_W] <= res_q[i];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      thr_q   <= THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_LIMIT: limit_q  <= cfg_data_i[LIMIT_W-1:0];
        REG_THR_ONE:      thr_q[0] <= cfg_data_i[THR_W-1:0];
        REG_THR_TWO:      thr_q[1] <= cfg_data_i[THR_W-1:0];
        REG_THR_THREE:    thr_q[2] <= cfg_data_i[THR_W-1:0];
        REG_THR_FOUR:     thr_q[3] <= cfg_data_i[THR_W-1:0];
        REG_THR_FIVE:     thr_q[4] <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_accept_starts_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == S_WIN))
    else $error("accepted sample did not enter the window step");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRD || state_q == S_CWR) |-> (k_q < CNT_IDX_W'(NUM_CNT)))
    else $error("counter index out of range");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_go |=> (m_axis_tvalid && win_fill == '0 && idx_q == '0))
    else $error("measurement end did not issue a result and clear");

endmodule
